// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rvdf_pkg.sv =====
// ---------------------------------------------------------------------------
// rvdf_pkg
// Shared constants and controller/datapath interface types for the
// recent-value duplicate filter.
// ---------------------------------------------------------------------------
package rvdf_pkg;

    // Default ring size is 2^SLOT_BITS entries
    localparam int SLOT_BITS_DEFAULT = 7;

    // Item payload widths
    localparam int VALUE_W     = 64;
    localparam int OUT_TDATA_W = 8;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch incoming value, restart the search
        logic scan_en;   // walk the ring, one read per cycle
        logic commit;    // load result register, append on a miss
    } rvdf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done; // all valid entries read and compared
        logic out_free;  // result register can take a new item
    } rvdf_sts_t;

endpackage

// ===== hw/rtl/rvdf_ctrl.sv =====
// ---------------------------------------------------------------------------
// rvdf_ctrl
// Sequencer: accept an item, run the ring search, commit the result.
// ---------------------------------------------------------------------------
module rvdf_ctrl
    import rvdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rvdf_sts_t sts,
    output rvdf_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/rvdf_datapath.sv =====
// ---------------------------------------------------------------------------
// rvdf_datapath
// History ring memory, write pointer, fill count, search counter, match
// flag and the result register.
// ---------------------------------------------------------------------------
module rvdf_datapath
    import rvdf_pkg::*;
#(
    parameter int SLOT_BITS = SLOT_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rvdf_cmd_t          cmd,
    output rvdf_sts_t          sts,
    input  logic [VALUE_W-1:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_seen
);

    localparam int DEPTH = 1 << SLOT_BITS;
    localparam logic [SLOT_BITS:0] SLOT_COUNT = {1'b1, {SLOT_BITS{1'b0}}};

    // Ring storage, no reset: only written slots are ever compared
    logic [VALUE_W-1:0] hist_mem [DEPTH];

    logic [VALUE_W-1:0]   value_reg;
    logic [VALUE_W-1:0]   rd_data_reg;
    logic [SLOT_BITS-1:0] wp_reg,      wp_next;
    logic [SLOT_BITS:0]   fill_reg,    fill_next;
    logic [SLOT_BITS:0]   scan_reg,    scan_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 hit_reg,     hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_seen_reg;

    logic                 issue;
    logic                 append;
    logic [SLOT_BITS-1:0] rd_addr;

    // Newest entry first: wp-1, wp-2, ...
    assign issue   = cmd.scan_en && (scan_reg < fill_reg);
    assign rd_addr = wp_reg - SLOT_BITS'(1) - scan_reg[SLOT_BITS-1:0];
    assign append  = cmd.commit && !hit_reg;

    assign sts.scan_done = (scan_reg >= fill_reg) && !rd_pend_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_seen  = out_seen_reg;

    // Next values for control state
    always_comb
    begin
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        rd_pend_next   = issue;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;

        if (cmd.capture)
        begin
            scan_next = '0;
            hit_next  = 1'b0;
        end
        else if (issue)
        begin
            scan_next = scan_reg + (SLOT_BITS+1)'(1);
        end

        // Compare the entry read last cycle
        if (rd_pend_reg && (rd_data_reg == value_reg))
        begin
            hit_next = 1'b1;
        end

        if (append)
        begin
            wp_next = wp_reg + SLOT_BITS'(1);
            if (fill_reg != SLOT_COUNT)
            begin
                fill_next = fill_reg + (SLOT_BITS+1)'(1);
            end
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            scan_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            rd_pend_reg   <= rd_pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= in_value;
        end
        if (cmd.commit)
        begin
            out_seen_reg <= hit_reg;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            hist_mem[wp_reg] <= value_reg;
        end
        if (issue)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/recent_value_dedup_filter_core.sv =====
// ---------------------------------------------------------------------------
// recent_value_dedup_filter_core
// Duplicate filter over a ring of the most recent distinct 64-bit values.
// ---------------------------------------------------------------------------
// Each input item carries one 64-bit value. The core reads the ring newest
// entry first, one entry per cycle from the ring memory, over the entries
// recorded so far (at most 2^SLOT_BITS). For each item the search reads every
// recorded entry, compares the last entry read and closes; the result is then
// committed to the result register. The input is taken again in the cycle
// after the commit, so a new item is not accepted before the previous one
// has committed, and acceptance is held off further while a waiting result
// holds back the commit. A match returns already_seen = 1 and leaves the
// ring alone; a miss writes the value at the write pointer, over the oldest
// slot once the ring is full, and returns 0. One item is in the search at a
// time; the next may be accepted while the previous result waits. No clearing
// pass is needed after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module recent_value_dedup_filter_core
    import rvdf_pkg::*;
#(
    parameter int SLOT_BITS = SLOT_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [63:0] value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] already_seen, [7:1] zero
);

    rvdf_cmd_t cmd;
    rvdf_sts_t sts;
    logic      seen;

    // Sequencer
    rvdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Ring and search datapath
    rvdf_datapath #(
        .SLOT_BITS (SLOT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_value  (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_seen  (seen)
    );

    assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, seen};

    // Checks
    `ASSERT_CLK(a_commit_free, !cmd.commit || sts.out_free, "commit while result register busy")
    `ASSERT_CLK(a_commit_done, !cmd.commit || sts.scan_done, "commit before search finished")
    `ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken during search")

endmodule
